@@ hdl/tss_pkg.sv @@
// ----------------------------------------------------------------------------
// tss_pkg
// Shared constants and types for the task scheduler with counting semaphores.
// ----------------------------------------------------------------------------
package tss_pkg;

   // task and semaphore counts
   localparam int TASKS = 4;
   localparam int SEMS  = 4;

   // derived widths
   localparam int TASK_W  = (TASKS > 1) ? $clog2(TASKS) : 1;
   localparam int SEM_W   = (SEMS > 1) ? $clog2(SEMS) : 1;
   localparam int LEN_W   = $clog2(TASKS + 1);
   localparam int QADDR_W = (SEMS * TASKS > 1) ? $clog2(SEMS * TASKS) : 1;

   // semaphore count limits
   localparam int CNT_FLOOR = -TASKS;
   localparam int CNT_CEIL  = 15;

   // event kinds
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_SLEEP = 2'd1;
   localparam logic [1:0] KIND_P     = 2'd2;
   localparam logic [1:0] KIND_V     = 2'd3;

   // one row of the task table
   typedef struct packed {
      logic [7:0]  slice;
      logic [15:0] sleep;
   } task_entry_type;

endpackage

@@ hdl/tss_req_if.sv @@
// ----------------------------------------------------------------------------
// tss_req_if
// Event channel: one kernel event per transfer.
// ----------------------------------------------------------------------------
interface tss_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] sleep_amount;
   logic [1:0]  sem_index;

   modport source (output valid, kind, sleep_amount, sem_index, input ready);
   modport sink   (input valid, kind, sleep_amount, sem_index, output ready);
endinterface

@@ hdl/tss_rsp_if.sv @@
// ----------------------------------------------------------------------------
// tss_rsp_if
// Result channel: one scheduling result per transfer.
// ----------------------------------------------------------------------------
interface tss_rsp_if;
   logic              valid;
   logic              ready;
   logic [1:0]        running_task;
   logic              no_ready;
   logic              caller_blocked;
   logic              woken_valid;
   logic [1:0]        woken_task;
   logic signed [4:0] sem_count;

   modport source (output valid, running_task, no_ready, caller_blocked, woken_valid,
                   woken_task, sem_count, input ready);
   modport sink   (input valid, running_task, no_ready, caller_blocked, woken_valid,
                   woken_task, sem_count, output ready);
endinterface

@@ hdl/task_scheduler_with_semaphores_core.sv @@
// ----------------------------------------------------------------------------
// task_scheduler_with_semaphores_core
// Time-slice task scheduler with counting semaphores and FIFO wait queues.
// ----------------------------------------------------------------------------
// One event is taken at a time. Tick and sleep events, and a P that blocks,
// run a schedule pass over the task table memory: one scan that ages sleep
// counters and picks the task with most slice left, and, when no runnable
// task has slice, a second scan that reloads slices from priority. A P or V
// without a pass goes to the result state, through a wait queue memory read
// first when a V releases a waiting task. The next event is taken while a
// result waits on rsp_if. After reset the task table is cleared entry by
// entry, during which no event is taken.
// Priorities sit at byte addresses 0..12, initial semaphore counts at 16..28.
module task_scheduler_with_semaphores_core (
   input  logic        clock,
   input  logic        reset,
   tss_req_if.sink     req_if,
   tss_rsp_if.source   rsp_if,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_TSCAN = 3'd1;
   localparam logic [2:0] ST_RSCAN = 3'd2;
   localparam logic [2:0] ST_QREAD = 3'd3;
   localparam logic [2:0] ST_RESP  = 3'd4;
   localparam logic [2:0] ST_CLEAR = 3'd5;

   // saturate a 7 bit count into the 5 bit result
   function automatic logic signed [4:0] sat5(input logic signed [6:0] v);
      if (v > 7'sd15)
         return 5'sd15;
      else if (v < -7'sd16)
         return -5'sd16;
      else
         return v[4:0];
   endfunction

   // configuration registers
   logic [7:0] prio_ff [4];
   logic [3:0] sem_init_ff [4];

   // control state
   logic [2:0]                 state_ff, state_in;
   logic [tss_pkg::TASK_W-1:0] running_ff, running_in;
   logic [tss_pkg::TASKS-1:0]  blocked_ff, blocked_in;
   logic signed [5:0]          sem_net_ff [tss_pkg::SEMS];
   logic signed [5:0]          sem_net_in [tss_pkg::SEMS];
   logic [tss_pkg::TASK_W-1:0] q_head_ff [tss_pkg::SEMS];
   logic [tss_pkg::TASK_W-1:0] q_head_in [tss_pkg::SEMS];
   logic [tss_pkg::LEN_W-1:0]  q_len_ff [tss_pkg::SEMS];
   logic [tss_pkg::LEN_W-1:0]  q_len_in [tss_pkg::SEMS];
   logic [tss_pkg::LEN_W-1:0]  iss_ff, iss_in;
   logic                       dv_ff, dv_in;
   logic                       found_ff, found_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // event and scan payload
   logic [1:0]                 kind_ff, kind_in;
   logic [15:0]                amount_ff, amount_in;
   logic [tss_pkg::TASK_W-1:0] didx_ff, didx_in;
   logic [7:0]                 top_ff, top_in;
   logic [tss_pkg::TASK_W-1:0] best_ff, best_in;
   logic                       nr_ff, nr_in;
   logic                       blk_ff, blk_in;
   logic                       wv_ff, wv_in;
   logic [tss_pkg::TASK_W-1:0] wt_ff, wt_in;
   logic signed [4:0]          cnt_ff, cnt_in;

   // result register
   logic [1:0]        r_run_ff, r_run_in;
   logic              r_nr_ff, r_nr_in;
   logic              r_blk_ff, r_blk_in;
   logic              r_wv_ff, r_wv_in;
   logic [1:0]        r_wt_ff, r_wt_in;
   logic signed [4:0] r_cnt_ff, r_cnt_in;

   // task table memory
   tss_pkg::task_entry_type    tmem [tss_pkg::TASKS];
   tss_pkg::task_entry_type    tmem_rd_ff;
   logic                       tmem_we;
   logic [tss_pkg::TASK_W-1:0] tmem_wa, tmem_ra;
   tss_pkg::task_entry_type    tmem_wd;

   // wait queue memory
   logic [tss_pkg::TASK_W-1:0]  qmem [tss_pkg::SEMS * tss_pkg::TASKS];
   logic [tss_pkg::TASK_W-1:0]  q_rd_ff;
   logic                        qmem_we;
   logic [tss_pkg::QADDR_W-1:0] qmem_wa, qmem_ra;
   logic [tss_pkg::TASK_W-1:0]  qmem_wd;

   // addressed semaphore of the incoming event
   logic [tss_pkg::SEM_W-1:0]  si;
   logic                       sem_ok;
   logic signed [6:0]          cur_cnt, new_cnt;
   logic [tss_pkg::LEN_W-1:0]  cur_len;
   logic [tss_pkg::TASK_W-1:0] cur_head;
   int                         tail_pos, head_pos;

   // scan datapath
   tss_pkg::task_entry_type ent;
   logic                    runnable;
   logic                    cand;
   logic                    fin_found;
   logic [tss_pkg::TASK_W-1:0] fin_best;

   assign si       = req_if.sem_index[tss_pkg::SEM_W-1:0];
   assign sem_ok   = int'(req_if.sem_index) < tss_pkg::SEMS;
   assign cur_cnt  = $signed({3'b000, sem_init_ff[2'(si)]}) +
                     $signed({sem_net_ff[si][5], sem_net_ff[si]});
   assign cur_len  = q_len_ff[si];
   assign cur_head = q_head_ff[si];

   // queue positions, wrapped once
   always_comb begin
      tail_pos = int'(cur_head) + int'(cur_len);
      if (tail_pos >= tss_pkg::TASKS)
         tail_pos = tail_pos - tss_pkg::TASKS;
      head_pos = int'(cur_head) + 1;
      if (head_pos >= tss_pkg::TASKS)
         head_pos = 0;
   end

   // configuration port
   assign csr_pready = 1'b1;
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[4])
         csr_prdata = {28'd0, sem_init_ff[csr_paddr[3:2]]};
      else
         csr_prdata = {24'd0, prio_ff[csr_paddr[3:2]]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prio_ff        <= '{8'd10, 8'd10, 8'd10, 8'd10};
         sem_init_ff[0] <= 4'd1;
         sem_init_ff[1] <= 4'd3;
         sem_init_ff[2] <= 4'd0;
         sem_init_ff[3] <= 4'd0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         if (csr_paddr[4])
            sem_init_ff[csr_paddr[3:2]] <= csr_pwdata[3:0];
         else
            prio_ff[csr_paddr[3:2]] <= csr_pwdata[7:0];
      end
   end

   // task table memory, one read and one write port
   always_ff @(posedge clock) begin
      if (tmem_we)
         tmem[tmem_wa] <= tmem_wd;
      tmem_rd_ff <= tmem[tmem_ra];
   end

   // wait queue memory
   always_ff @(posedge clock) begin
      if (qmem_we)
         qmem[qmem_wa] <= qmem_wd;
      q_rd_ff <= qmem[qmem_ra];
   end

   assign qmem_ra = tss_pkg::QADDR_W'(int'(si) * tss_pkg::TASKS + int'(cur_head));

   assign req_if.ready = (state_ff == ST_IDLE);

   // sequencer and datapath
   always_comb begin
      state_in     = state_ff;
      running_in   = running_ff;
      blocked_in   = blocked_ff;
      sem_net_in   = sem_net_ff;
      q_head_in    = q_head_ff;
      q_len_in     = q_len_ff;
      iss_in       = iss_ff;
      dv_in        = 1'b0;
      didx_in      = iss_ff[tss_pkg::TASK_W-1:0];
      found_in     = found_ff;
      top_in       = top_ff;
      best_in      = best_ff;
      kind_in      = kind_ff;
      amount_in    = amount_ff;
      nr_in        = nr_ff;
      blk_in       = blk_ff;
      wv_in        = wv_ff;
      wt_in        = wt_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      r_run_in     = r_run_ff;
      r_nr_in      = r_nr_ff;
      r_blk_in     = r_blk_ff;
      r_wv_in      = r_wv_ff;
      r_wt_in      = r_wt_ff;
      r_cnt_in     = r_cnt_ff;
      tmem_we      = 1'b0;
      tmem_wa      = didx_ff;
      tmem_ra      = iss_ff[tss_pkg::TASK_W-1:0];
      tmem_wd      = tmem_rd_ff;
      qmem_we      = 1'b0;
      qmem_wa      = tss_pkg::QADDR_W'(int'(si) * tss_pkg::TASKS + tail_pos);
      qmem_wd      = running_ff;
      new_cnt      = cur_cnt;
      ent          = tmem_rd_ff;
      runnable     = 1'b0;
      cand         = 1'b0;
      fin_found    = found_ff;
      fin_best     = best_ff;

      case (state_ff)
         // zero the task table after reset, one entry a cycle
         ST_CLEAR: begin
            tmem_we = 1'b1;
            tmem_wa = iss_ff[tss_pkg::TASK_W-1:0];
            tmem_wd = '0;
            if (int'(iss_ff) == tss_pkg::TASKS - 1) begin
               iss_in   = '0;
               state_in = ST_IDLE;
            end else begin
               iss_in = iss_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (req_if.valid) begin
               kind_in   = req_if.kind;
               amount_in = req_if.sleep_amount;
               nr_in     = 1'b0;
               blk_in    = 1'b0;
               wv_in     = 1'b0;
               wt_in     = '0;
               cnt_in    = '0;
               iss_in    = '0;
               top_in    = '0;
               found_in  = 1'b0;
               state_in  = ST_RESP;
               case (req_if.kind)
                  tss_pkg::KIND_TICK, tss_pkg::KIND_SLEEP: begin
                     state_in = ST_TSCAN;
                  end
                  tss_pkg::KIND_P: begin
                     if (sem_ok) begin
                        cnt_in = sat5(cur_cnt);
                        if (int'(cur_cnt) > tss_pkg::CNT_FLOOR &&
                            (cur_cnt > 7'sd0 || int'(cur_len) < tss_pkg::TASKS)) begin
                           new_cnt        = cur_cnt - 7'sd1;
                           cnt_in         = sat5(new_cnt);
                           sem_net_in[si] = sem_net_ff[si] - 6'sd1;
                           // block the caller at the queue tail
                           if (new_cnt < 7'sd0) begin
                              blocked_in[running_ff] = 1'b1;
                              qmem_we      = 1'b1;
                              q_len_in[si] = cur_len + 1'b1;
                              blk_in       = 1'b1;
                              state_in     = ST_TSCAN;
                           end
                        end
                     end
                  end
                  default: begin
                     if (sem_ok) begin
                        cnt_in = sat5(cur_cnt);
                        if (int'(cur_cnt) < tss_pkg::CNT_CEIL) begin
                           new_cnt        = cur_cnt + 7'sd1;
                           cnt_in         = sat5(new_cnt);
                           sem_net_in[si] = sem_net_ff[si] + 6'sd1;
                           // queue head is read this cycle
                           if (new_cnt <= 7'sd0 && cur_len != '0) begin
                              q_head_in[si] = tss_pkg::TASK_W'(head_pos);
                              q_len_in[si]  = cur_len - 1'b1;
                              state_in      = ST_QREAD;
                           end
                        end
                     end
                  end
               endcase
            end
         end

         // release the head of the queue
         ST_QREAD: begin
            wv_in               = 1'b1;
            wt_in               = q_rd_ff;
            blocked_in[q_rd_ff] = 1'b0;
            state_in            = ST_RESP;
         end

         ST_TSCAN, ST_RSCAN: begin
            // issue reads
            if (int'(iss_ff) < tss_pkg::TASKS) begin
               iss_in = iss_ff + 1'b1;
               dv_in  = 1'b1;
            end
            // modify and write back the entry read last cycle
            if (dv_ff) begin
               if (state_ff == ST_TSCAN) begin
                  if (didx_ff == running_ff) begin
                     if (kind_ff == tss_pkg::KIND_TICK && ent.slice != 8'd0)
                        ent.slice = ent.slice - 8'd1;
                     if (kind_ff == tss_pkg::KIND_SLEEP)
                        ent.sleep = amount_ff;
                  end
                  if (ent.sleep != 16'd0)
                     ent.sleep = ent.sleep - 16'd1;
               end
               runnable = !blocked_ff[didx_ff] && ent.sleep == 16'd0;
               if (state_ff == ST_RSCAN && runnable)
                  ent.slice = prio_ff[2'(didx_ff)];
               tmem_we = 1'b1;
               tmem_wd = ent;
               // running maximum, lowest index wins ties
               cand = runnable && ent.slice > top_ff;
               if (cand) begin
                  top_in    = ent.slice;
                  best_in   = didx_ff;
                  found_in  = 1'b1;
                  fin_found = 1'b1;
                  fin_best  = didx_ff;
               end
               // end of a scan
               if (int'(didx_ff) == tss_pkg::TASKS - 1) begin
                  dv_in = 1'b0;
                  if (fin_found) begin
                     running_in = fin_best;
                     state_in   = ST_RESP;
                  end else if (state_ff == ST_TSCAN) begin
                     iss_in   = '0;
                     top_in   = '0;
                     found_in = 1'b0;
                     state_in = ST_RSCAN;
                  end else begin
                     nr_in    = 1'b1;
                     state_in = ST_RESP;
                  end
               end
            end
         end

         // hand the result to the output register
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               r_run_in     = 2'(running_ff);
               r_nr_in      = nr_ff;
               r_blk_in     = blk_ff;
               r_wv_in      = wv_ff;
               r_wt_in      = 2'(wt_ff);
               r_cnt_in     = cnt_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         running_ff   <= '0;
         blocked_ff   <= '0;
         sem_net_ff   <= '{default: '0};
         q_head_ff    <= '{default: '0};
         q_len_ff     <= '{default: '0};
         iss_ff       <= '0;
         dv_ff        <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         blocked_ff   <= blocked_in;
         sem_net_ff   <= sem_net_in;
         q_head_ff    <= q_head_in;
         q_len_ff     <= q_len_in;
         iss_ff       <= iss_in;
         dv_ff        <= dv_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      amount_ff <= amount_in;
      didx_ff   <= didx_in;
      top_ff    <= top_in;
      best_ff   <= best_in;
      nr_ff     <= nr_in;
      blk_ff    <= blk_in;
      wv_ff     <= wv_in;
      wt_ff     <= wt_in;
      cnt_ff    <= cnt_in;
      r_run_ff  <= r_run_in;
      r_nr_ff   <= r_nr_in;
      r_blk_ff  <= r_blk_in;
      r_wv_ff   <= r_wv_in;
      r_wt_ff   <= r_wt_in;
      r_cnt_ff  <= r_cnt_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.running_task   = r_run_ff;
   assign rsp_if.no_ready       = r_nr_ff;
   assign rsp_if.caller_blocked = r_blk_ff;
   assign rsp_if.woken_valid    = r_wv_ff;
   assign rsp_if.woken_task     = r_wt_ff;
   assign rsp_if.sem_count      = r_cnt_ff;

endmodule
